FILE: sv/cell_supervisor_sequencer_top_macros.svh
// Assertion macros used by the cell supervisor sequencer back end
`ifndef CELL_SUPERVISOR_SEQUENCER_TOP_MACROS_SVH
`define CELL_SUPERVISOR_SEQUENCER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define CSS_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("csseq check failed");
// next-cycle implication
`define CSS_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("csseq check failed");
`else
`define CSS_ASSERT_NOW(name, clk, rst_n, ante, cons)
`define CSS_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif

`endif

FILE: sv/csseq_pkg.sv
// Types, codes and helpers of the cell supervisor sequencer
`default_nettype none

package csseq_pkg;

    localparam int COUNT_BITS   = 16;
    localparam int TOTAL_BITS   = 16;
    localparam int CMP_BITS     = (COUNT_BITS > TOTAL_BITS) ? COUNT_BITS : TOTAL_BITS;
    localparam int MISS_BITS    = 8;
    localparam int CMD_BITS     = 4;
    localparam int STATUS_BITS  = 4;
    localparam int DEV_BITS     = 2;
    localparam int RUN_MAX      = 6;
    localparam int LEN_BITS     = $clog2(RUN_MAX + 1);
    localparam int IDX_BITS     = $clog2(RUN_MAX);
    localparam int QDEPTH       = 2;
    localparam int QPTR_BITS    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_BITS    = $clog2(QDEPTH + 1);
    localparam int S_TDATA_BITS = 8;
    localparam int M_TDATA_BITS = 56;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_BITS     = 16;

    typedef logic [COUNT_BITS-1:0]  count_t;
    typedef logic [TOTAL_BITS-1:0]  total_t;
    typedef logic [MISS_BITS-1:0]   miss_t;
    typedef logic [CMD_BITS-1:0]    cmd_t;
    typedef logic [STATUS_BITS-1:0] status_t;
    typedef logic [DEV_BITS-1:0]    dev_t;
    typedef logic [LEN_BITS-1:0]    len_t;
    typedef logic [IDX_BITS-1:0]    idx_t;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_INSPECT  = 3'd1,
        PH_PICK     = 3'd2,
        PH_PLACE    = 3'd3,
        PH_REJECT   = 3'd4,
        PH_FINISHED = 3'd5,
        PH_FAULTED  = 3'd6
    } phase_t;

    // command codes
    localparam cmd_t CMD_HEARTBEAT     = 4'd0;
    localparam cmd_t CMD_HOME          = 4'd1;
    localparam cmd_t CMD_CONV_START    = 4'd2;
    localparam cmd_t CMD_REQUEST_PART  = 4'd3;
    localparam cmd_t CMD_PICK          = 4'd4;
    localparam cmd_t CMD_REMOVE_REJECT = 4'd5;
    localparam cmd_t CMD_PLACE         = 4'd6;
    localparam cmd_t CMD_CONV_STOP     = 4'd7;
    localparam cmd_t CMD_CONV_SHUTDOWN = 4'd8;
    localparam cmd_t CMD_ROBOT_SHUTDOWN = 4'd9;
    localparam cmd_t CMD_VIS_SHUTDOWN  = 4'd10;
    localparam cmd_t CMD_ROBOT_STOP    = 4'd11;

    // frame sources
    localparam dev_t DEV_VISION   = 2'd0;
    localparam dev_t DEV_ROBOT    = 2'd1;
    localparam dev_t DEV_CONVEYOR = 2'd2;
    localparam dev_t DEV_OTHER    = 2'd3;

    // device status codes
    localparam status_t VIS_HB          = 4'd0;
    localparam status_t VIS_FAULT       = 4'd1;
    localparam status_t VIS_TIMEOUT     = 4'd2;
    localparam status_t VIS_ACCEPT      = 4'd3;
    localparam status_t VIS_REJECT      = 4'd4;
    localparam status_t ROB_HB          = 4'd0;
    localparam status_t ROB_FAIL_FIRST  = 4'd1;
    localparam status_t ROB_FAIL_LAST   = 4'd3;
    localparam status_t ROB_PICK_DONE   = 4'd4;
    localparam status_t ROB_PLACE_DONE  = 4'd5;
    localparam status_t ROB_REJECT_DONE = 4'd6;
    localparam status_t CONV_ALIVE_LAST = 4'd4;
    localparam status_t CONV_FAULT      = 4'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_TARGET_CYCLES = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_HB_TIMEOUT    = 2'd1;

    localparam logic [CFG_BITS-1:0] TARGET_RESET  = CFG_BITS'(1);
    localparam miss_t               TIMEOUT_RESET = miss_t'(3);

    // one run of commands with the state snapshot it reports
    typedef struct packed {
        cmd_t [RUN_MAX-1:0] cmds;
        len_t               len;
        phase_t             phase;
        total_t             accepted;
        total_t             rejected;
        total_t             processed;
    } run_t;

    function automatic count_t sat_count(input count_t v);
        return (v == '1) ? v : count_t'(v + count_t'(1));
    endfunction

    function automatic miss_t sat_miss(input miss_t v);
        return (v == '1) ? v : miss_t'(v + miss_t'(1));
    endfunction

endpackage

`default_nettype wire

FILE: sv/csseq_front.sv
// Front end: accepts events, runs the phase machine and builds command runs
`default_nettype none

module csseq_front
    import csseq_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    input  wire logic [S_TDATA_BITS-1:0] s_tdata,   // source_device, payload_present, status_code
    input  wire logic                    s_tuser,   // req_type
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [CFG_BITS-1:0]     cfg_data,
    output logic                         push_valid,
    input  wire logic                    push_ready,
    output run_t                         push_data
);

    phase_t  phase_reg, phase_next;
    logic    started_reg, started_next;
    logic    fault_latch_reg, fault_latch_next;
    miss_t   conv_miss_reg, conv_miss_next;
    miss_t   robot_miss_reg, robot_miss_next;
    miss_t   vis_miss_reg, vis_miss_next;
    count_t  acc_reg, acc_next;
    count_t  rej_reg, rej_next;
    count_t  proc_reg, proc_next;
    logic [CFG_BITS-1:0] target_reg;
    miss_t   timeout_reg;

    logic    accept;
    logic    is_tick;
    dev_t    source;
    logic    payload;
    status_t status;
    logic    fault_hit;
    logic    cycle_done;
    run_t    run_c;

    assign source    = s_tdata[1:0];
    assign payload   = s_tdata[2];
    assign status    = s_tdata[6:3];
    assign is_tick   = s_tuser;
    assign s_tready  = push_ready;
    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;

    always_comb
    begin
        phase_next       = phase_reg;
        started_next     = started_reg;
        fault_latch_next = fault_latch_reg;
        conv_miss_next   = conv_miss_reg;
        robot_miss_next  = robot_miss_reg;
        vis_miss_next    = vis_miss_reg;
        acc_next         = acc_reg;
        rej_next         = rej_reg;
        proc_next        = proc_reg;
        fault_hit        = 1'b0;
        cycle_done       = 1'b0;
        run_c.cmds       = '0;
        run_c.len        = '0;

        if (is_tick)
        begin
            if (phase_reg != PH_FINISHED && phase_reg != PH_FAULTED)
            begin
                run_c.cmds[0]   = CMD_HEARTBEAT;
                run_c.len       = len_t'(1);
                conv_miss_next  = sat_miss(conv_miss_reg);
                robot_miss_next = sat_miss(robot_miss_reg);
                vis_miss_next   = sat_miss(vis_miss_reg);
                if (conv_miss_next >= timeout_reg || robot_miss_next >= timeout_reg ||
                    vis_miss_next >= timeout_reg)
                begin
                    phase_next       = PH_FAULTED;
                    fault_latch_next = 1'b1;
                    if (!fault_latch_reg)
                    begin
                        run_c.cmds[1] = CMD_CONV_SHUTDOWN;
                        run_c.cmds[2] = CMD_ROBOT_SHUTDOWN;
                        run_c.cmds[3] = CMD_VIS_SHUTDOWN;
                        run_c.cmds[4] = CMD_ROBOT_STOP;
                        run_c.cmds[5] = CMD_CONV_STOP;
                        run_c.len     = len_t'(6);
                    end
                end
                else if (!started_reg)
                begin
                    started_next  = 1'b1;
                    run_c.cmds[1] = CMD_HOME;
                    run_c.cmds[2] = CMD_CONV_START;
                    run_c.cmds[3] = CMD_REQUEST_PART;
                    run_c.len     = len_t'(4);
                    phase_next    = PH_INSPECT;
                end
            end
        end
        else if (payload)
        begin
            unique case (source)
                DEV_VISION:
                begin
                    if (status == VIS_HB)
                        vis_miss_next = '0;
                    else if (status == VIS_FAULT || status == VIS_TIMEOUT)
                        fault_hit = 1'b1;
                    else if (phase_reg == PH_INSPECT && status == VIS_ACCEPT)
                    begin
                        run_c.cmds[0] = CMD_PICK;
                        run_c.len     = len_t'(1);
                        phase_next    = PH_PICK;
                    end
                    else if (phase_reg == PH_INSPECT && status == VIS_REJECT)
                    begin
                        run_c.cmds[0] = CMD_REMOVE_REJECT;
                        run_c.len     = len_t'(1);
                        phase_next    = PH_REJECT;
                    end
                end
                DEV_ROBOT:
                begin
                    if (status == ROB_HB)
                        robot_miss_next = '0;
                    else if (status >= ROB_FAIL_FIRST && status <= ROB_FAIL_LAST)
                        fault_hit = 1'b1;
                    else if (phase_reg == PH_PICK && status == ROB_PICK_DONE)
                    begin
                        run_c.cmds[0] = CMD_PLACE;
                        run_c.len     = len_t'(1);
                        phase_next    = PH_PLACE;
                    end
                    else if (phase_reg == PH_PLACE && status == ROB_PLACE_DONE)
                    begin
                        acc_next   = sat_count(acc_reg);
                        cycle_done = 1'b1;
                    end
                    else if (phase_reg == PH_REJECT && status == ROB_REJECT_DONE)
                    begin
                        rej_next   = sat_count(rej_reg);
                        cycle_done = 1'b1;
                    end
                end
                DEV_CONVEYOR:
                begin
                    if (status <= CONV_ALIVE_LAST)
                        conv_miss_next = '0;
                    else if (status == CONV_FAULT)
                        fault_hit = 1'b1;
                end
                DEV_OTHER:
                begin
                end
                default:
                begin
                end
            endcase
        end

        if (fault_hit)
        begin
            phase_next       = PH_FAULTED;
            fault_latch_next = 1'b1;
            if (!fault_latch_reg)
            begin
                run_c.cmds[0] = CMD_CONV_SHUTDOWN;
                run_c.cmds[1] = CMD_ROBOT_SHUTDOWN;
                run_c.cmds[2] = CMD_VIS_SHUTDOWN;
                run_c.cmds[3] = CMD_ROBOT_STOP;
                run_c.cmds[4] = CMD_CONV_STOP;
                run_c.len     = len_t'(5);
            end
        end

        if (cycle_done)
        begin
            proc_next = sat_count(proc_reg);
            run_c.len = len_t'(1);
            if (CMP_BITS'(proc_next) >= CMP_BITS'(target_reg))
            begin
                run_c.cmds[0] = CMD_CONV_STOP;
                phase_next    = PH_FINISHED;
            end
            else
            begin
                run_c.cmds[0] = CMD_REQUEST_PART;
                phase_next    = PH_INSPECT;
            end
        end

        run_c.phase     = phase_next;
        run_c.accepted  = total_t'(acc_next);
        run_c.rejected  = total_t'(rej_next);
        run_c.processed = total_t'(proc_next);
    end

    assign push_valid = accept && (run_c.len != '0);
    assign push_data  = run_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            started_reg     <= 1'b0;
            fault_latch_reg <= 1'b0;
            conv_miss_reg   <= '0;
            robot_miss_reg  <= '0;
            vis_miss_reg    <= '0;
            acc_reg         <= '0;
            rej_reg         <= '0;
            proc_reg        <= '0;
            target_reg      <= TARGET_RESET;
            timeout_reg     <= TIMEOUT_RESET;
        end
        else
        begin
            if (accept)
            begin
                phase_reg       <= phase_next;
                started_reg     <= started_next;
                fault_latch_reg <= fault_latch_next;
                conv_miss_reg   <= conv_miss_next;
                robot_miss_reg  <= robot_miss_next;
                vis_miss_reg    <= vis_miss_next;
                acc_reg         <= acc_next;
                rej_reg         <= rej_next;
                proc_reg        <= proc_next;
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_TARGET_CYCLES)
                    target_reg <= cfg_data;
                else if (cfg_index == REG_HB_TIMEOUT)
                    timeout_reg <= cfg_data[MISS_BITS-1:0];
            end
        end
    end

endmodule

`default_nettype wire

FILE: sv/csseq_fifo.sv
// Short queue of command runs between the front and back ends
`default_nettype none

module csseq_fifo
    import csseq_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push_valid,
    output logic      push_ready,
    input  wire run_t push_data,
    output logic      pop_valid,
    input  wire logic pop_ready,
    output run_t      pop_data
);

    run_t                 mem_reg [QDEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg;
    logic [QPTR_BITS-1:0] rd_ptr_reg;
    logic [QCNT_BITS-1:0] count_reg;
    logic                 do_push;
    logic                 do_pop;

    assign push_ready = (count_reg != QCNT_BITS'(QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == QPTR_BITS'(QDEPTH - 1)) ? '0
                              : QPTR_BITS'(wr_ptr_reg + QPTR_BITS'(1));
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == QPTR_BITS'(QDEPTH - 1)) ? '0
                              : QPTR_BITS'(rd_ptr_reg + QPTR_BITS'(1));
            if (do_push && !do_pop)
                count_reg <= QCNT_BITS'(count_reg + QCNT_BITS'(1));
            else if (do_pop && !do_push)
                count_reg <= QCNT_BITS'(count_reg - QCNT_BITS'(1));
        end
    end

endmodule

`default_nettype wire

FILE: sv/csseq_back.sv
// Back end: drains one command run as a sequence of output beats
`default_nettype none
`include "cell_supervisor_sequencer_top_macros.svh"

module csseq_back
    import csseq_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     pop_valid,
    output logic                          pop_ready,
    input  wire run_t                     pop_data,
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    output logic [M_TDATA_BITS-1:0]       m_tdata,
    output logic                          m_tlast
);

    run_t  run_reg;
    logic  run_valid_reg;
    idx_t  idx_reg;
    logic  beat;
    logic  is_last;

    assign is_last   = (len_t'(idx_reg) + len_t'(1) == run_reg.len);
    assign beat      = run_valid_reg && m_tready;
    // load the next run when empty or while the last beat leaves
    assign pop_ready = !run_valid_reg || (beat && is_last);

    assign m_tvalid = run_valid_reg;
    assign m_tlast  = is_last;
    assign m_tdata  = {1'b0, run_reg.processed, run_reg.rejected, run_reg.accepted,
                       run_reg.phase, run_reg.cmds[idx_reg]};

    always_ff @(posedge clk)
    begin
        if (pop_valid && pop_ready)
            run_reg <= pop_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            if (pop_valid && pop_ready)
            begin
                run_valid_reg <= 1'b1;
                idx_reg       <= '0;
            end
            else if (beat && is_last)
            begin
                run_valid_reg <= 1'b0;
                idx_reg       <= '0;
            end
            else if (beat)
                idx_reg <= idx_t'(idx_reg + idx_t'(1));
        end
    end

    `CSS_ASSERT_NOW(a_run_in_range, clk, rst_n, run_valid_reg,
                    run_reg.len != '0 && len_t'(idx_reg) < run_reg.len)
    `CSS_ASSERT_NEXT(a_last_rewinds, clk, rst_n, m_tvalid && m_tready && m_tlast,
                     idx_reg == '0)
    `CSS_ASSERT_NEXT(a_beat_advances, clk, rst_n, m_tvalid && m_tready && !m_tlast,
                     run_valid_reg && idx_reg == idx_t'($past(idx_reg) + idx_t'(1)))

endmodule

`default_nettype wire

FILE: sv/cell_supervisor_sequencer_top.sv
// Top level of the pick-and-place cell supervisor sequencer
//
//  channel  dir  beat on               contents
//  s_*      in   s_tvalid & s_tready   one event: tick or device status frame
//  m_*      out  m_tvalid & m_tready   one command plus phase and part counters
//  cfg_*    in   cfg_valid & cfg_ready register write (0 target cycles, 1 hb timeout)
//
// An event is taken whenever the run queue has room; its state update is done in
// that cycle, and it yields a run of zero to six commands. Commands leave at one
// beat per cycle from the output stage while m_tready is high. The first beat of
// a run is offered once the run has passed through the queue and been loaded into
// the output stage register. Reset clears all control state at once, no clearing
// pass. A stall on m_* fills the two-entry queue before s_tready drops.
`default_nettype none

module cell_supervisor_sequencer_top
    import csseq_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    input  wire logic [S_TDATA_BITS-1:0] s_tdata,  // source_device[1:0], payload_present[2],
                                                   // status_code[6:3], zero pad[7]
    input  wire logic                    s_tuser,  // req_type
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    output logic [M_TDATA_BITS-1:0]      m_tdata,  // command_code[3:0], phase_now[6:4],
                                                   // accepted_total[22:7],
                                                   // rejected_total[38:23],
                                                   // processed_total[54:39], zero pad[55]
    output logic                         m_tlast,  // last_of_run
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [CFG_BITS-1:0]     cfg_data
);

    logic push_valid;
    logic push_ready;
    run_t push_data;
    logic pop_valid;
    logic pop_ready;
    run_t pop_data;

    csseq_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    csseq_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    csseq_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire
